// ===== hdl/rvdos_pkg.sv =====
`default_nettype none

package rvdos_pkg;

  // Major opcodes, instruction bits 6:0
  localparam logic [6:0] OPC_RTYPE  = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  // funct7 codes of the R-type group
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

  typedef enum logic [4:0] {
    AOP_NOP  = 5'd0,
    AOP_ADD  = 5'd1,
    AOP_SUB  = 5'd2,
    AOP_MUL  = 5'd3,
    AOP_SLL  = 5'd4,
    AOP_SLT  = 5'd5,
    AOP_SLTU = 5'd6,
    AOP_DIV  = 5'd7,
    AOP_XOR  = 5'd8,
    AOP_SRL  = 5'd9,
    AOP_SRA  = 5'd10,
    AOP_DIVU = 5'd11,
    AOP_REM  = 5'd12,
    AOP_OR   = 5'd13,
    AOP_REMU = 5'd14,
    AOP_AND  = 5'd15,
    AOP_CMP  = 5'd16
  } alu_op_t;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_LOAD  = 2'd1,
    MOP_STORE = 2'd2
  } mem_op_t;

  // Instruction class, decoded from the opcode in the first stage
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_RTYPE,
    CLS_OPIMM,
    CLS_LOAD,
    CLS_STORE,
    CLS_BRANCH,
    CLS_LUI,
    CLS_JAL
  } instr_class_t;

  // Source of the displacement operand
  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_REG,
    DSEL_IMM
  } disp_sel_t;

endpackage

`default_nettype wire

// ===== hdl/rvdos_in_if.sv =====
`default_nettype none

interface rvdos_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [31:0] source_one_value;
  logic [31:0] source_two_value;

  modport source (
    output valid, instruction_word, source_one_value, source_two_value,
    input  ready
  );
  modport sink (
    input  valid, instruction_word, source_one_value, source_two_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/rvdos_out_if.sv =====
`default_nettype none

interface rvdos_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_register;
  logic [4:0]  alu_operation;
  logic [1:0]  memory_operation;
  logic [31:0] left_operand;
  logic [31:0] right_operand;
  logic [31:0] displacement;

  modport source (
    output valid, dest_register, alu_operation, memory_operation,
           left_operand, right_operand, displacement,
    input  ready
  );
  modport sink (
    input  valid, dest_register, alu_operation, memory_operation,
           left_operand, right_operand, displacement,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/rv32im_decode_operand_select_unit.sv =====
`default_nettype none

// Channel   Dir  Word contents
// --------  ---  ---------------------------------------------------------------
// in_word   in   instruction_word, source_one_value, source_two_value
// out_word  out  dest_register, alu/memory op, left/right operand, displacement
//
// Three register stages: opcode class (S1), ALU/memory op and immediate build
// (S2), operand select into the output register (S3). out_word.valid rises when
// a taken word has moved through S1 and S2 into S3; one word enters every cycle
// when out_word.ready stays high. rst_n (synchronous, active low) empties all
// stages. A stage advances when it is empty or the stage after it advances, so
// a stall at the output holds in place every full stage with no empty stage
// after it, while empty slots still fill.

module rv32im_decode_operand_select_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  rvdos_in_if.sink     in_word,
  rvdos_out_if.source  out_word
);

  // ---------------------------------------------------------------------------
  // Stage handshake: ready ripples back from the output register
  // ---------------------------------------------------------------------------
  logic [2:0] v_r;
  logic       adv1, adv2, adv3;

  assign adv3 = !v_r[2] || out_word.ready;
  assign adv2 = !v_r[1] || adv3;
  assign adv1 = !v_r[0] || adv2;

  assign in_word.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv1) v_r[0] <= in_word.valid;
      if (adv2) v_r[1] <= v_r[0];
      if (adv3) v_r[2] <= v_r[1];
    end
  end

  // ---------------------------------------------------------------------------
  // S1: capture the word, classify the opcode
  // ---------------------------------------------------------------------------
  rvdos_pkg::instr_class_t cls_nxt, cls_s1_r;
  logic [31:0]             instr_s1_r, r1_s1_r, r2_s1_r;

  always_comb begin
    unique case (in_word.instruction_word[6:0])
      rvdos_pkg::OPC_RTYPE:  cls_nxt = rvdos_pkg::CLS_RTYPE;
      rvdos_pkg::OPC_OPIMM:  cls_nxt = rvdos_pkg::CLS_OPIMM;
      rvdos_pkg::OPC_LOAD:   cls_nxt = rvdos_pkg::CLS_LOAD;
      rvdos_pkg::OPC_STORE:  cls_nxt = rvdos_pkg::CLS_STORE;
      rvdos_pkg::OPC_BRANCH: cls_nxt = rvdos_pkg::CLS_BRANCH;
      rvdos_pkg::OPC_LUI:    cls_nxt = rvdos_pkg::CLS_LUI;
      rvdos_pkg::OPC_JAL:    cls_nxt = rvdos_pkg::CLS_JAL;
      default:               cls_nxt = rvdos_pkg::CLS_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      cls_s1_r   <= cls_nxt;
      instr_s1_r <= in_word.instruction_word;
      r1_s1_r    <= in_word.source_one_value;
      r2_s1_r    <= in_word.source_two_value;
    end
  end

  // ---------------------------------------------------------------------------
  // S2: ALU op, memory op, immediates and operand steering
  // ---------------------------------------------------------------------------
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

  rvdos_pkg::alu_op_t   aop_nxt, aop_s2_r;
  rvdos_pkg::mem_op_t   mop_nxt, mop_s2_r;
  rvdos_pkg::disp_sel_t dsel_nxt, dsel_s2_r;
  logic [31:0]          lhs_nxt, lhs_s2_r;
  logic [31:0]          rimm_nxt, rimm_s2_r;
  logic [31:0]          dimm_nxt, dimm_s2_r;
  logic                 rreg_nxt, rreg_s2_r;
  logic [4:0]           rd_s2_r;
  logic [31:0]          r2_s2_r;

  assign f3 = instr_s1_r[14:12];
  assign f7 = instr_s1_r[31:25];

  assign imm_i = {{20{instr_s1_r[31]}}, instr_s1_r[31:20]};
  assign imm_s = {{20{instr_s1_r[31]}}, instr_s1_r[31:25], instr_s1_r[11:7]};
  assign imm_b = {{19{instr_s1_r[31]}}, instr_s1_r[31], instr_s1_r[7],
                  instr_s1_r[30:25], instr_s1_r[11:8], 1'b0};
  assign imm_j = {{11{instr_s1_r[31]}}, instr_s1_r[31], instr_s1_r[19:12],
                  instr_s1_r[20], instr_s1_r[30:21], 1'b0};
  assign imm_u = instr_s1_r & rvdos_pkg::UPPER_MASK;

  // R-type op: funct3 1..3 ignore funct7; an unknown funct7 on add or shift
  // gives nop but still passes both register values
  function automatic rvdos_pkg::alu_op_t rtype_op(input logic [2:0] fn3,
                                                  input logic [6:0] fn7);
    logic md;
    md = (fn7 == rvdos_pkg::F7_MULDIV);
    unique case (fn3)
      rvdos_pkg::F3_ADD: begin
        priority if (fn7 == rvdos_pkg::F7_BASE) rtype_op = rvdos_pkg::AOP_ADD;
        else if (fn7 == rvdos_pkg::F7_ALT)      rtype_op = rvdos_pkg::AOP_SUB;
        else if (md)                            rtype_op = rvdos_pkg::AOP_MUL;
        else                                    rtype_op = rvdos_pkg::AOP_NOP;
      end
      rvdos_pkg::F3_SLL:  rtype_op = rvdos_pkg::AOP_SLL;
      rvdos_pkg::F3_SLT:  rtype_op = rvdos_pkg::AOP_SLT;
      rvdos_pkg::F3_SLTU: rtype_op = rvdos_pkg::AOP_SLTU;
      rvdos_pkg::F3_XOR:  rtype_op = md ? rvdos_pkg::AOP_DIV : rvdos_pkg::AOP_XOR;
      rvdos_pkg::F3_SR: begin
        priority if (fn7 == rvdos_pkg::F7_BASE) rtype_op = rvdos_pkg::AOP_SRL;
        else if (fn7 == rvdos_pkg::F7_ALT)      rtype_op = rvdos_pkg::AOP_SRA;
        else if (md)                            rtype_op = rvdos_pkg::AOP_DIVU;
        else                                    rtype_op = rvdos_pkg::AOP_NOP;
      end
      rvdos_pkg::F3_OR:   rtype_op = md ? rvdos_pkg::AOP_REM : rvdos_pkg::AOP_OR;
      default:            rtype_op = md ? rvdos_pkg::AOP_REMU : rvdos_pkg::AOP_AND;
    endcase
  endfunction

  function automatic rvdos_pkg::alu_op_t opimm_op(input logic [2:0] fn3,
                                                  input logic       alt);
    unique case (fn3)
      rvdos_pkg::F3_ADD:  opimm_op = rvdos_pkg::AOP_ADD;
      rvdos_pkg::F3_SLL:  opimm_op = rvdos_pkg::AOP_SLL;
      rvdos_pkg::F3_SLT:  opimm_op = rvdos_pkg::AOP_SLT;
      rvdos_pkg::F3_SLTU: opimm_op = rvdos_pkg::AOP_SLTU;
      rvdos_pkg::F3_XOR:  opimm_op = rvdos_pkg::AOP_XOR;
      rvdos_pkg::F3_SR:   opimm_op = alt ? rvdos_pkg::AOP_SRA : rvdos_pkg::AOP_SRL;
      rvdos_pkg::F3_OR:   opimm_op = rvdos_pkg::AOP_OR;
      default:            opimm_op = rvdos_pkg::AOP_AND;
    endcase
  endfunction

  always_comb begin
    aop_nxt  = rvdos_pkg::AOP_NOP;
    mop_nxt  = rvdos_pkg::MOP_NONE;
    dsel_nxt = rvdos_pkg::DSEL_ZERO;
    lhs_nxt  = '0;
    rimm_nxt = '0;
    dimm_nxt = '0;
    rreg_nxt = 1'b0;
    unique case (cls_s1_r)
      rvdos_pkg::CLS_RTYPE: begin
        aop_nxt  = rtype_op(f3, f7);
        lhs_nxt  = r1_s1_r;
        rreg_nxt = 1'b1;
      end
      rvdos_pkg::CLS_OPIMM: begin
        aop_nxt  = opimm_op(f3, instr_s1_r[30]);
        lhs_nxt  = r1_s1_r;
        rimm_nxt = imm_i;
      end
      rvdos_pkg::CLS_LOAD: begin
        aop_nxt  = rvdos_pkg::AOP_ADD;
        mop_nxt  = rvdos_pkg::MOP_LOAD;
        lhs_nxt  = r1_s1_r;
        rimm_nxt = imm_i;
      end
      rvdos_pkg::CLS_STORE: begin
        aop_nxt  = rvdos_pkg::AOP_ADD;
        mop_nxt  = rvdos_pkg::MOP_STORE;
        lhs_nxt  = r1_s1_r;
        rimm_nxt = imm_s;
        dsel_nxt = rvdos_pkg::DSEL_REG;
      end
      rvdos_pkg::CLS_BRANCH: begin
        aop_nxt  = rvdos_pkg::AOP_CMP;
        lhs_nxt  = r1_s1_r;
        rreg_nxt = 1'b1;
        dimm_nxt = imm_b;
        dsel_nxt = rvdos_pkg::DSEL_IMM;
      end
      rvdos_pkg::CLS_LUI: begin
        aop_nxt  = rvdos_pkg::AOP_ADD;
        rimm_nxt = imm_u;
      end
      rvdos_pkg::CLS_JAL: begin
        dimm_nxt = imm_j;
        dsel_nxt = rvdos_pkg::DSEL_IMM;
      end
      default: begin
        // unknown opcode: everything stays zero
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      aop_s2_r  <= aop_nxt;
      mop_s2_r  <= mop_nxt;
      dsel_s2_r <= dsel_nxt;
      lhs_s2_r  <= lhs_nxt;
      rimm_s2_r <= rimm_nxt;
      dimm_s2_r <= dimm_nxt;
      rreg_s2_r <= rreg_nxt;
      rd_s2_r   <= instr_s1_r[11:7];
      r2_s2_r   <= r2_s1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // S3: final operand select into the output register
  // ---------------------------------------------------------------------------
  logic [31:0] rhs_nxt, disp_nxt;
  logic [31:0] lhs_r, rhs_r, disp_r;
  logic [4:0]  rd_r, aop_r;
  logic [1:0]  mop_r;

  assign rhs_nxt = rreg_s2_r ? r2_s2_r : rimm_s2_r;

  always_comb begin
    unique case (dsel_s2_r)
      rvdos_pkg::DSEL_REG: disp_nxt = r2_s2_r;
      rvdos_pkg::DSEL_IMM: disp_nxt = dimm_s2_r;
      default:             disp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      rd_r   <= rd_s2_r;
      aop_r  <= aop_s2_r;
      mop_r  <= mop_s2_r;
      lhs_r  <= lhs_s2_r;
      rhs_r  <= rhs_nxt;
      disp_r <= disp_nxt;
    end
  end

  assign out_word.valid            = v_r[2];
  assign out_word.dest_register    = rd_r;
  assign out_word.alu_operation    = aop_r;
  assign out_word.memory_operation = mop_r;
  assign out_word.left_operand     = lhs_r;
  assign out_word.right_operand    = rhs_r;
  assign out_word.displacement     = disp_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted word always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> v_r[0])
    else $error("accepted word did not reach stage 1");

  // Memory accesses always compute their address with an add
  a_mem_uses_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && (out_word.memory_operation != rvdos_pkg::MOP_NONE)
      |-> out_word.alu_operation == rvdos_pkg::AOP_ADD)
    else $error("memory op without add");

  // Loads carry no displacement
  a_load_no_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && (out_word.memory_operation == rvdos_pkg::MOP_LOAD)
      |-> out_word.displacement == '0)
    else $error("load with nonzero displacement");

  // A full output stage that is stalled blocks the middle stage from moving
  a_stall_holds_s2: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !out_word.ready && v_r[1] |=> v_r[1] && v_r[2])
    else $error("stage 2 lost during output stall");

endmodule

`default_nettype wire
